// File: sv/wei_pkg.sv
// Shared types and constants for the sliding-window extremum detector.
// No dependencies; imported by every module of the block.
package wei_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int MAX_HALF_DEF   = 8;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths
    localparam int IDX_BITS    = 32;
    localparam int CNT_BITS    = 32;
    localparam int HW_CFG_BITS = 4;

    localparam logic [HW_CFG_BITS-1:0] HW_RESET = HW_CFG_BITS'(1);

    // Extremum kind codes
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    // Per-cell compare result against the window centre
    typedef struct packed {
        logic no_max;   // this entry is >= centre, so the centre is no maximum
        logic no_min;   // this entry is <= centre, so the centre is no minimum
    } cmp_t;

    // Per-kind tracker view of the next extremum of that kind
    typedef struct packed {
        logic                seen;
        logic [IDX_BITS-1:0] interval;
        logic [CNT_BITS-1:0] count;
    } trk_t;

endpackage

// File: sv/wei_cell.sv
// One window entry: holds a sample, hands it to the next cell on a shift,
// and compares its value with the broadcast centre value. Uses wei_pkg.
module wei_cell #(
    parameter int VALUE_BITS = wei_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          shift,
    input  logic signed [VALUE_BITS-1:0]  value_in,
    input  logic [wei_pkg::IDX_BITS-1:0]  index_in,
    input  logic signed [VALUE_BITS-1:0]  centre_value,
    input  logic                          active,
    output logic signed [VALUE_BITS-1:0]  value_out,
    output logic [wei_pkg::IDX_BITS-1:0]  index_out,
    output wei_pkg::cmp_t                 cmp
);
    import wei_pkg::*;

    logic signed [VALUE_BITS-1:0] value_reg;
    logic [IDX_BITS-1:0]          index_reg;

    // Advance the sample one place down the chain
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= value_in;
            index_reg <= index_in;
        end
    end

    assign value_out = value_reg;
    assign index_out = index_reg;

    // Flag entries that spoil a strict maximum or minimum
    always_comb
    begin
        cmp.no_max = active && (value_reg >= centre_value);
        cmp.no_min = active && (value_reg <= centre_value);
    end

endmodule

// File: sv/wei_tracker.sv
// Per-kind bookkeeping: last extremum index, seen flag and running count.
// Uses wei_pkg; instantiated once for maxima and once for minima.
module wei_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         hit,
    input  logic [wei_pkg::IDX_BITS-1:0] index,
    output wei_pkg::trk_t                info
);
    import wei_pkg::*;

    logic [IDX_BITS-1:0] last_reg;
    logic                seen_reg;
    logic [CNT_BITS-1:0] total_reg;

    // Record each extremum of this kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            seen_reg  <= 1'b0;
            total_reg <= '0;
        end
        else if (hit)
        begin
            last_reg  <= index;
            seen_reg  <= 1'b1;
            total_reg <= total_reg + CNT_BITS'(1);
        end
    end

    // Distance to the previous one, zero when there is none
    always_comb
    begin
        info.seen     = seen_reg;
        info.interval = seen_reg ? (index - last_reg) : '0;
        info.count    = total_reg + CNT_BITS'(1);
    end

endmodule

// File: sv/window_extremum_interval_top.sv
// Sliding-window local extremum detector, top level.
// Depends on wei_pkg, wei_cell (window chain) and wei_tracker (per-kind state).
//
//  port group        dir  payload
//  s_tvalid/tready   in   s_tdata: sample_index[31:0], sample_value[47:32]
//  m_tvalid/tready   out  m_tuser: extremum_kind; m_tdata: extremum_index,
//                         interval_valid, interval, kind_count
//  cfg_we/cfg_wdata  in   half_width
//
// Each sample is first shifted into the cell chain; then every cell is
// compared with the centre and the output register is loaded. The
// compare of one sample overlaps the shift of the next, so one sample per
// cycle is sustained while the output register drains. A full output
// register that is not taken holds the compare and thus the input side.
// Reset (rst_n, async) clears the fill count, the trackers and both valids.
module window_extremum_interval_top #(
    parameter int MAX_HALF   = wei_pkg::MAX_HALF_DEF,
    parameter int VALUE_BITS = wei_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // Input stream
    input  logic s_tvalid,
    output logic s_tready,
    // [31:0] sample_index, [31+VALUE_BITS:32] sample_value, rest zero
    input  logic [((wei_pkg::IDX_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Result stream
    output logic m_tvalid,
    input  logic m_tready,
    // [31:0] extremum_index, [32] interval_valid, [64:33] interval,
    // [96:65] kind_count, [103:97] zero
    output logic [103:0] m_tdata,
    // [0] extremum_kind
    output logic m_tuser,
    // Configuration
    input  logic cfg_we,
    input  logic [wei_pkg::HW_CFG_BITS-1:0] cfg_wdata
);
    import wei_pkg::*;

    localparam int DEPTH     = 2 * MAX_HALF + 1;
    localparam int FILL_BITS = $clog2(DEPTH + 1);
    localparam int HW_BITS   = $clog2(MAX_HALF + 1);
    localparam int SEL_BITS  = $clog2(DEPTH);

    logic [HW_CFG_BITS-1:0] half_width_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic                   pending_reg;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [IDX_BITS-1:0]    out_index_reg;
    logic                   out_ivalid_reg;
    logic [IDX_BITS-1:0]    out_interval_reg;
    logic [CNT_BITS-1:0]    out_count_reg;

    logic                   in_xfer;
    logic                   eval_fire;
    logic [HW_BITS-1:0]     hw;
    logic [FILL_BITS-1:0]   win_len;
    logic                   win_full;

    logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [IDX_BITS-1:0]          cell_index [DEPTH];
    cmp_t                         cell_cmp   [DEPTH];
    logic [DEPTH-1:0]             no_max_vec;
    logic [DEPTH-1:0]             no_min_vec;
    logic signed [VALUE_BITS-1:0] centre_value;
    logic [IDX_BITS-1:0]          centre_index;
    logic                         is_max;
    logic                         is_min;
    trk_t                         max_info;
    trk_t                         min_info;

    // Handshake: compare runs once a shift has left a sample pending, overlapping the next
    assign eval_fire = pending_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pending_reg || eval_fire;
    assign in_xfer   = s_tvalid && s_tready;

    // Clamp the configured half width into 1..MAX_HALF
    always_comb
    begin
        if (half_width_reg == '0)
            hw = HW_BITS'(1);
        else if (32'(half_width_reg) > MAX_HALF)
            hw = HW_BITS'(MAX_HALF);
        else
            hw = HW_BITS'(half_width_reg);
        win_len  = FILL_BITS'({hw, 1'b1});
        win_full = (fill_reg >= win_len);
    end

    // Pick the centre entry
    assign centre_value = cell_value[SEL_BITS'(hw)];
    assign centre_index = cell_index[SEL_BITS'(hw)];

    // Window chain, newest sample in cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0] value_in;
        logic [IDX_BITS-1:0]          index_in;
        logic                         active;

        if (i == 0)
        begin : g_head
            assign value_in = s_tdata[IDX_BITS +: VALUE_BITS];
            assign index_in = s_tdata[IDX_BITS-1:0];
        end
        else
        begin : g_link
            assign value_in = cell_value[i-1];
            assign index_in = cell_index[i-1];
        end

        assign active = (FILL_BITS'(i) < win_len) && (SEL_BITS'(i) != SEL_BITS'(hw));

        wei_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .shift       (in_xfer),
            .value_in    (value_in),
            .index_in    (index_in),
            .centre_value(centre_value),
            .active      (active),
            .value_out   (cell_value[i]),
            .index_out   (cell_index[i]),
            .cmp         (cell_cmp[i])
        );

        assign no_max_vec[i] = cell_cmp[i].no_max;
        assign no_min_vec[i] = cell_cmp[i].no_min;
    end

    // Reduce the cell flags; a maximum takes precedence
    assign is_max = win_full && !(|no_max_vec);
    assign is_min = win_full && !(|no_min_vec) && !is_max;

    // Per-kind trackers
    wei_tracker u_max_trk (
        .clk  (clk),
        .rst_n(rst_n),
        .hit  (eval_fire && is_max),
        .index(centre_index),
        .info (max_info)
    );

    wei_tracker u_min_trk (
        .clk  (clk),
        .rst_n(rst_n),
        .hit  (eval_fire && is_min),
        .index(centre_index),
        .info (min_info)
    );

    // Control state: config, fill count, compare pending, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HW_RESET;
            fill_reg       <= '0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                half_width_reg <= cfg_wdata;
            if (in_xfer && (fill_reg < FILL_BITS'(DEPTH)))
                fill_reg <= fill_reg + FILL_BITS'(1);
            pending_reg <= in_xfer || (pending_reg && !eval_fire);
            if (eval_fire)
                out_valid_reg <= is_max || is_min;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            out_index_reg <= centre_index;
            if (is_max)
            begin
                out_kind_reg     <= KIND_MAX;
                out_ivalid_reg   <= max_info.seen;
                out_interval_reg <= max_info.interval;
                out_count_reg    <= max_info.count;
            end
            else
            begin
                out_kind_reg     <= KIND_MIN;
                out_ivalid_reg   <= min_info.seen;
                out_interval_reg <= min_info.interval;
                out_count_reg    <= min_info.count;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_interval_reg, out_ivalid_reg, out_index_reg};

endmodule

// File: dv/tb.sv
// Testbench for window_extremum_interval_top: directed and random sample streams
// with random stalls on both stream ports, checked against an in-bench predictor.
// Depends on wei_pkg and the RTL of the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wei_pkg::*;

    localparam int DEPTH      = 2 * MAX_HALF_DEF + 1;
    localparam int VAL_BITS   = VALUE_BITS_DEF;
    localparam int IN_BITS    = ((IDX_BITS + VAL_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 104;
    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD  = 80;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 125;

    // One detected extremum as it leaves the block
    typedef struct packed {
        logic                kind;
        logic [IDX_BITS-1:0] index;
        logic                ivalid;
        logic [IDX_BITS-1:0] interval;
        logic [CNT_BITS-1:0] count;
    } extremum_t;

    // Window model plus the queue of extrema still owed by the block
    class extremum_scoreboard;
        logic [HW_CFG_BITS-1:0]    half_width;
        logic signed [VAL_BITS-1:0] win_val [DEPTH];
        logic [IDX_BITS-1:0]       win_idx [DEPTH];
        int                        fill;
        logic [IDX_BITS-1:0]       last_idx [2];
        bit                        seen [2];
        logic [CNT_BITS-1:0]       total [2];
        extremum_t                 owed_q [$];
        int                        errors;

        function new();
            half_width = HW_RESET;
            fill = 0;
            errors = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                win_val[i] = '0;
                win_idx[i] = '0;
            end
            for (int k = 0; k < 2; k++)
            begin
                last_idx[k] = '0;
                seen[k] = 1'b0;
                total[k] = '0;
            end
        endfunction

        function void set_half_width(logic [HW_CFG_BITS-1:0] value);
            half_width = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Shift a sample in and test the centre of the active window
        function void note_sample(logic [IDX_BITS-1:0] idx, logic signed [VAL_BITS-1:0] val);
            int                         hw;
            int                         span;
            bit                         is_max;
            bit                         is_min;
            logic signed [VAL_BITS-1:0] centre;
            extremum_t                  r;
            for (int i = DEPTH - 1; i > 0; i--)
            begin
                win_val[i] = win_val[i-1];
                win_idx[i] = win_idx[i-1];
            end
            win_val[0] = val;
            win_idx[0] = idx;
            if (fill < DEPTH)
                fill++;

            // Clamp the width: zero acts as one, oversize acts as the maximum
            hw = (half_width == 0) ? 1 : ((half_width > MAX_HALF_DEF) ? MAX_HALF_DEF : half_width);
            span = 2 * hw + 1;
            if (fill < span)
                return;

            centre = win_val[hw];
            is_max = 1'b1;
            is_min = 1'b1;
            for (int i = 0; i < span; i++)
            begin
                if (i != hw)
                begin
                    if (win_val[i] >= centre)
                        is_max = 1'b0;
                    if (win_val[i] <= centre)
                        is_min = 1'b0;
                end
            end
            if (!is_max && !is_min)
                return;

            // A maximum wins; a minimum only counts when no maximum was found
            r.kind = is_max ? KIND_MAX : KIND_MIN;
            r.index = win_idx[hw];
            r.ivalid = seen[r.kind];
            r.interval = seen[r.kind] ? win_idx[hw] - last_idx[r.kind] : '0;
            total[r.kind] = total[r.kind] + 1'b1;
            r.count = total[r.kind];
            last_idx[r.kind] = win_idx[hw];
            seen[r.kind] = 1'b1;
            owed_q.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        // Compare one result transfer with the oldest owed extremum
        function void check_result(logic kind, logic [OUT_BITS-1:0] data);
            extremum_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got kind %b data %h",
                         $time, kind, data);
                return;
            end
            e = owed_q.pop_front();
            check_field("extremum_kind", 32'(e.kind), 32'(kind));
            check_field("extremum_index", e.index, data[31:0]);
            check_field("interval_valid", 32'(e.ivalid), 32'(data[32]));
            check_field("interval", e.interval, data[64:33]);
            check_field("kind_count", e.count, data[96:65]);
            check_field("padding", 32'h0, 32'(data[103:97]));
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [IN_BITS-1:0]            s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [OUT_BITS-1:0]           m_tdata;
    logic                          m_tuser;
    logic                          cfg_we;
    logic [HW_CFG_BITS-1:0]        cfg_wdata;

    extremum_scoreboard sb;
    bit                 calm;
    bit                 long_hold_req;
    int unsigned        idle_cycles;
    logic [IDX_BITS-1:0] next_idx;

    window_extremum_interval_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int unsigned rx_stall;
        m_tready = 1'b0;
        rx_stall = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rx_stall = LONG_HOLD;
            end
            else if (rx_stall == 0 && !calm && $urandom_range(0, 9) == 0)
                rx_stall = $urandom_range(1, 8);
            if (rx_stall != 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Offer one sample, with an optional random gap first; returns at a falling edge
    task automatic send_sample(logic [IDX_BITS-1:0] idx, logic [VAL_BITS-1:0] val);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_BITS'({val, idx});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(idx, val);
        @(negedge clk);
    endtask

    // Stop offering and wait for every owed extremum
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Write half_width once the block has gone idle
    task automatic write_half_width(logic [HW_CFG_BITS-1:0] value);
        drain();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        sb.set_half_width(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random samples in segments: triangle waves give clean extrema, the rest
    // are uniform noise, small-range plateaus and rail-to-rail values
    task automatic run_phase(int count, bit hold_rx, bit pause_tx);
        int mode;
        int seg_left;
        int tri_val;
        int tri_step;
        logic [VAL_BITS-1:0] val;
        seg_left = 0;
        mode = 0;
        tri_val = $urandom_range(0, 2000) - 1000;
        tri_step = $urandom_range(1, 2000);
        for (int n = 0; n < count; n++)
        begin
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 6);
                seg_left = $urandom_range(4, 24);
            end
            seg_left--;
            if (hold_rx && n == count / 3)
                long_hold_req = 1'b1;
            if (pause_tx && n == count / 2)
                drain();

            // Advance the index, with occasional jumps and wraps
            case ($urandom_range(0, 15))
                0:       next_idx = $urandom;
                1:       next_idx = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: next_idx = next_idx + $urandom_range(1, 4);
            endcase

            case (mode)
                0, 1, 2, 3:
                begin
                    if ($urandom_range(0, 5) == 0)
                        tri_step = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 2000);
                    tri_val = tri_val + tri_step;
                    if (tri_val > 32767 || tri_val < -32768)
                    begin
                        tri_val = (tri_val > 32767) ? 32767 : -32768;
                        tri_step = -tri_step;
                    end
                    val = VAL_BITS'(tri_val);
                end
                4:       val = VAL_BITS'($urandom);
                5:       val = VAL_BITS'(int'($urandom_range(0, 3)) - 2);
                default:
                    case ($urandom_range(0, 2))
                        0:       val = 16'h8000;
                        1:       val = 16'h7FFF;
                        default: val = 16'h0000;
                    endcase
            endcase
            send_sample(next_idx, val);
        end
    endtask

    // Directed opening at the reset width: rails, plateaus, index wrap
    logic [IDX_BITS-1:0] dir_idx [18] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0003,
        32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 32'h8000_0000, 32'h0000_0008,
        32'h0000_0009, 32'h0000_000A, 32'h0000_000B, 32'h0000_000C, 32'h0000_000D,
        32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0002
    };
    logic [VAL_BITS-1:0] dir_val [18] = '{
        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C,
        16'h0064, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
        16'h0001, 16'h7FFF, 16'h7FFF
    };

    // Width plan: clamped low, maximum, oversize, then a mix
    logic [HW_CFG_BITS-1:0] width_plan [PHASES] = '{
        4'd0, 4'd8, 4'd15, 4'd2, 4'd1, 4'd5, 4'd0, 4'd0, 4'd0, 4'd3
    };

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles = 0;
        next_idx = '0;
        sb = new();

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 18; i++)
            send_sample(dir_idx[i], dir_val[i]);

        // Random phases, each under its own width
        for (int p = 0; p < PHASES; p++)
        begin
            if (p >= 6 && p <= 8)
                write_half_width(HW_CFG_BITS'($urandom_range(0, 15)));
            else
                write_half_width(width_plan[p]);
            if (p == PHASES - 1)
                calm = 1'b1;
            run_phase(PHASE_LEN, p == 3, p == 4);
        end

        // Let the last results drain, then settle
        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// File: window_extremum_interval_top.f
sv/wei_pkg.sv
sv/wei_cell.sv
sv/wei_tracker.sv
sv/window_extremum_interval_top.sv
dv/tb.sv
